>>> hdl/wfd_pkg.sv
// ----------------------------------------------------------------------------
// wfd_pkg
// Shared constants, command/status types and the CRC-32 byte update for the
// WEP frame decryptor.
// ----------------------------------------------------------------------------
package wfd_pkg;

    // Body length at which the byte counter stops counting
    localparam int MAX_BODY = 4096;
    localparam int CNT_W    = $clog2(MAX_BODY + 1);

    // S-box geometry
    localparam int SBOX_DEPTH = 256;
    localparam int SBOX_AW    = $clog2(SBOX_DEPTH);

    // Configuration register indexes
    localparam logic [1:0] CFG_KEY_LENGTH = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW    = 2'd1;
    localparam logic [1:0] CFG_KEY_HIGH   = 2'd2;

    // Key length limits and reset value
    localparam logic [3:0] KEY_LEN_MAX   = 4'd13;
    localparam logic [3:0] KEY_LEN_RESET = 4'd5;
    localparam int         IV_BYTES      = 3;

    // Frame status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_SHORT    = 2'd2;

    // Body positions that change the handling of a word
    localparam logic [CNT_W-1:0] POS_IV_LAST = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_CIPHER  = CNT_W'(4);
    localparam logic [CNT_W-1:0] POS_ICV_MIN = CNT_W'(7);
    localparam logic [CNT_W-1:0] POS_PAYLOAD = CNT_W'(8);

    // CRC-32, reflected
    localparam logic [31:0] CRC_POLY   = 32'hedb88320;
    localparam logic [31:0] CRC_PRESET = 32'hffffffff;

    // Datapath operations
    localparam logic [3:0] OP_NOP  = 4'd0;
    localparam logic [3:0] OP_TAKE = 4'd1;  // latch the input word
    localparam logic [3:0] OP_FILL = 4'd2;  // write identity into the S-box
    localparam logic [3:0] OP_RD_N = 4'd3;  // read s[n] or s[i+1]
    localparam logic [3:0] OP_RD_J = 4'd4;  // advance j, read s[j]
    localparam logic [3:0] OP_SWAP = 4'd5;  // write back the swapped pair
    localparam logic [3:0] OP_RD_T = 4'd6;  // read s[s_i + s_j]
    localparam logic [3:0] OP_CAP  = 4'd7;  // capture the keystream byte
    localparam logic [3:0] OP_FIN  = 4'd8;  // retire the word

    typedef struct packed {
        logic [3:0] op;
        logic       sched;   // key schedule rather than keystream
    } t_cmd;

    typedef struct packed {
        logic pos_iv_last;   // word is the third IV byte
        logic pos_cipher;    // word is ciphertext or ICV
        logic last;          // latched word ends the frame
        logic n_last;        // schedule counter at its final entry
        logic has_res;       // retiring the word gives a result
        logic out_free;      // output register can take a result
    } t_stat;

    // One byte through the reflected CRC-32
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> hdl/wep_frame_decrypt_icv_check_top.sv
// ----------------------------------------------------------------------------
// wep_frame_decrypt_icv_check_top
// WEP frame body decryptor: RC4 keystream over IV || key, CRC-32 ICV check.
// ----------------------------------------------------------------------------
// Feed the frame body one word per byte: three IV bytes, the key-id byte, the
// ciphertext and the four ICV bytes, with i_last_byte on the final one. Plain
// payload words come out four bytes late; the last word's result carries
// o_frame_done and o_frame_status (ok, mismatch, too short). IV and key-id
// words are taken, dispatched and retired; ciphertext words also run the five
// S-box accesses of one RC4 step on the dual-port S-box RAM. After the third
// IV byte the block refills the S-box and runs the key schedule (read, j update
// and swap per entry) before taking the next word. A finished result waits in
// the output register while the next word is taken.
// Configuration writes are always ready and must be made between frames.
// ----------------------------------------------------------------------------
module wep_frame_decrypt_icv_check_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_plain_byte,
    output logic        o_plain_valid,
    output logic        o_frame_done,
    output logic [1:0]  o_frame_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import wfd_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    wfd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    wfd_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_frame_byte   (i_frame_byte),
        .i_last_byte    (i_last_byte),
        .i_cfg_we       (i_cfg_valid & o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_plain_byte   (o_plain_byte),
        .o_plain_valid  (o_plain_valid),
        .o_frame_done   (o_frame_done),
        .o_frame_status (o_frame_status)
    );

endmodule

>>> hdl/wfd_ram.sv
// ----------------------------------------------------------------------------
// wfd_ram
// Generic true dual-port RAM, one write or read per port per cycle, read data
// registered.
// ----------------------------------------------------------------------------
module wfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_a_we,
    input  logic [$clog2(DEPTH)-1:0] i_a_addr,
    input  logic [WIDTH-1:0]         i_a_wdata,
    output logic [WIDTH-1:0]         o_a_rdata,
    input  logic                     i_b_we,
    input  logic [$clog2(DEPTH)-1:0] i_b_addr,
    input  logic [WIDTH-1:0]         i_b_wdata,
    output logic [WIDTH-1:0]         o_b_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Port A
    always_ff @(posedge i_clk) begin
        if (i_a_we) begin
            r_mem[i_a_addr] <= i_a_wdata;
        end
        o_a_rdata <= r_mem[i_a_addr];
    end

    // Port B
    always_ff @(posedge i_clk) begin
        if (i_b_we) begin
            r_mem[i_b_addr] <= i_b_wdata;
        end
        o_b_rdata <= r_mem[i_b_addr];
    end

endmodule

>>> hdl/wfd_datapath.sv
// ----------------------------------------------------------------------------
// wfd_datapath
// Key registers, S-box, RC4 indexes, delay line, CRC-32 and the output
// register. Driven one operation per cycle by the controller.
// ----------------------------------------------------------------------------
module wfd_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wfd_pkg::t_cmd i_cmd,
    output wfd_pkg::t_stat o_stat,
    input  logic [7:0]    i_frame_byte,
    input  logic          i_last_byte,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data,
    input  logic          i_stall,
    output logic          o_valid,
    output logic [7:0]    o_plain_byte,
    output logic          o_plain_valid,
    output logic          o_frame_done,
    output logic [1:0]    o_frame_status
);
    import wfd_pkg::*;

    logic [3:0]         r_key_len;
    logic [63:0]        r_key_lo;
    logic [39:0]        r_key_hi;
    logic [7:0]         r_byte;
    logic               r_last;
    logic [23:0]        r_iv;
    logic [CNT_W-1:0]   r_cnt;
    logic [7:0]         r_i, r_j, r_si, r_sj, r_ks;
    logic [SBOX_AW-1:0] r_n;
    logic [3:0]         r_k;
    logic [31:0]        r_crc;
    logic [7:0]         r_dly [4];
    logic               r_ov, r_pvalid, r_done;
    logic [7:0]         r_plain;
    logic [1:0]         r_status;

    logic               a_we, b_we;
    logic [SBOX_AW-1:0] a_addr, b_addr;
    logic [7:0]         a_wd, b_wd, a_rd, b_rd;
    logic [3:0]         key_eff, k_wrap;
    logic [127:0]       seed_vec;
    logic [7:0]         seed, j_new, dec;
    logic               p_ge8, has_res;
    logic [31:0]        crc_new;
    logic [1:0]         status;

    wfd_ram #(.WIDTH(8), .DEPTH(SBOX_DEPTH)) u_sbox (
        .i_clk     (i_clk),
        .i_a_we    (a_we),
        .i_a_addr  (a_addr),
        .i_a_wdata (a_wd),
        .o_a_rdata (a_rd),
        .i_b_we    (b_we),
        .i_b_addr  (b_addr),
        .i_b_wdata (b_wd),
        .o_b_rdata (b_rd)
    );

    // Seed byte n mod (key length + 3) taken from IV || key, key length clamped to 1..13
    always_comb begin
        key_eff = r_key_len;
        if (r_key_len == 4'd0) begin
            key_eff = 4'd1;
        end else if (r_key_len > KEY_LEN_MAX) begin
            key_eff = KEY_LEN_MAX;
        end
        k_wrap   = key_eff + 4'(IV_BYTES - 1);
        seed_vec = {r_key_hi, r_key_lo, r_iv};
        seed     = seed_vec[{r_k, 3'd0} +: 8];
        j_new    = r_j + a_rd + (i_cmd.sched ? seed : 8'd0);
    end

    // Retire arithmetic: decrypt, payload CRC and ICV compare
    always_comb begin
        p_ge8   = (r_cnt >= POS_PAYLOAD);
        has_res = p_ge8 | r_last;
        dec     = r_byte ^ r_ks;
        crc_new = p_ge8 ? crc_byte(r_crc, r_dly[0]) : r_crc;
        status  = ST_OK;
        if (r_cnt < POS_ICV_MIN) begin
            status = ST_SHORT;
        end else if (r_key_len == 4'd0) begin
            status = ST_MISMATCH;
        end else if ({dec, r_dly[3], r_dly[2], r_dly[1]} != ~crc_new) begin
            status = ST_MISMATCH;
        end
    end

    // S-box port control
    always_comb begin
        a_we   = 1'b0;
        b_we   = 1'b0;
        a_addr = r_n;
        b_addr = r_j;
        a_wd   = r_n;
        b_wd   = r_si;
        case (i_cmd.op)
            OP_FILL: begin
                a_we = 1'b1;
            end
            OP_RD_N: begin
                a_addr = i_cmd.sched ? r_n : r_i + 8'd1;
            end
            OP_RD_J: begin
                b_addr = j_new;
            end
            OP_SWAP: begin
                a_we   = 1'b1;
                b_we   = 1'b1;
                a_addr = i_cmd.sched ? r_n : r_i;
                a_wd   = b_rd;
            end
            OP_RD_T: begin
                a_addr = r_si + r_sj;
            end
            default: begin
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= KEY_LEN_RESET;
            r_key_lo  <= '0;
            r_key_hi  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_LENGTH: r_key_len <= i_cfg_data[3:0];
                CFG_KEY_LOW:    r_key_lo  <= i_cfg_data;
                CFG_KEY_HIGH:   r_key_hi  <= i_cfg_data[39:0];
                default: begin
                end
            endcase
        end
    end

    // Latched input word and keystream captures
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_TAKE) begin
            r_byte <= i_frame_byte;
        end
        if (i_cmd.op == OP_RD_J) begin
            r_si <= a_rd;
        end
        if (i_cmd.op == OP_SWAP) begin
            r_sj <= b_rd;
        end
        if (i_cmd.op == OP_CAP) begin
            r_ks <= a_rd;
        end
    end

    // Frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= 1'b0;
            r_iv   <= '0;
            r_cnt  <= '0;
            r_i    <= '0;
            r_j    <= '0;
            r_n    <= '0;
            r_k    <= '0;
            r_crc  <= CRC_PRESET;
            for (int d = 0; d < 4; d++) begin
                r_dly[d] <= '0;
            end
        end else begin
            case (i_cmd.op)
                OP_TAKE: begin
                    r_last <= i_last_byte;
                end
                OP_FILL: begin
                    r_n <= r_n + 1'b1;
                end
                OP_RD_N: begin
                    if (!i_cmd.sched) begin
                        r_i <= r_i + 8'd1;
                    end
                end
                OP_RD_J: begin
                    r_j <= j_new;
                end
                OP_SWAP: begin
                    if (i_cmd.sched) begin
                        r_n <= r_n + 1'b1;
                        r_k <= (r_k == k_wrap) ? 4'd0 : r_k + 4'd1;
                        // leave the indexes at zero once the schedule ends
                        if (r_n == SBOX_AW'(SBOX_DEPTH - 1)) begin
                            r_i <= '0;
                            r_j <= '0;
                            r_k <= '0;
                        end
                    end
                end
                OP_FIN: begin
                    if (r_cnt < POS_CIPHER - CNT_W'(1) && r_cnt <= POS_IV_LAST) begin
                        r_iv[{r_cnt[1:0], 3'd0} +: 8] <= r_byte;
                    end
                    if (r_cnt >= POS_CIPHER) begin
                        r_dly[0] <= r_dly[1];
                        r_dly[1] <= r_dly[2];
                        r_dly[2] <= r_dly[3];
                        r_dly[3] <= dec;
                    end
                    r_crc <= crc_new;
                    if (r_cnt < CNT_W'(MAX_BODY)) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    // end of frame: back to the reset values
                    if (r_last) begin
                        r_iv  <= '0;
                        r_cnt <= '0;
                        r_i   <= '0;
                        r_j   <= '0;
                        r_crc <= CRC_PRESET;
                        for (int d = 0; d < 4; d++) begin
                            r_dly[d] <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.op == OP_FIN && has_res) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FIN && has_res) begin
            r_pvalid <= p_ge8;
            r_plain  <= p_ge8 ? r_dly[0] : 8'd0;
            r_done   <= r_last;
            r_status <= r_last ? status : ST_OK;
        end
    end

    assign o_stat.pos_iv_last = (r_cnt == POS_IV_LAST);
    assign o_stat.pos_cipher  = (r_cnt >= POS_CIPHER);
    assign o_stat.last        = r_last;
    assign o_stat.n_last      = (r_n == SBOX_AW'(SBOX_DEPTH - 1));
    assign o_stat.has_res     = has_res;
    assign o_stat.out_free    = !r_ov || !i_stall;

    assign o_valid        = r_ov;
    assign o_plain_byte   = r_plain;
    assign o_plain_valid  = r_pvalid;
    assign o_frame_done   = r_done;
    assign o_frame_status = r_status;

endmodule

>>> hdl/wfd_ctrl.sv
// ----------------------------------------------------------------------------
// wfd_ctrl
// Sequencer: takes a word, runs one RC4 keystream step for every ciphertext word
// and retires the word; after the third IV byte it refills the S-box and runs the key schedule.
// ----------------------------------------------------------------------------
module wfd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  wfd_pkg::t_stat i_stat,
    output wfd_pkg::t_cmd  o_cmd
);
    import wfd_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_FILL = 4'd2;
    localparam logic [3:0] S_KRD  = 4'd3;
    localparam logic [3:0] S_KJ   = 4'd4;
    localparam logic [3:0] S_KSW  = 4'd5;
    localparam logic [3:0] S_SRD  = 4'd6;
    localparam logic [3:0] S_SJ   = 4'd7;
    localparam logic [3:0] S_SSW  = 4'd8;
    localparam logic [3:0] S_STR  = 4'd9;
    localparam logic [3:0] S_SCAP = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_sched, n_sched;

    // Next state and command
    always_comb begin
        n_state   = r_state;
        n_sched   = r_sched;
        o_cmd.op    = OP_NOP;
        o_cmd.sched = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_TAKE;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                n_sched = i_stat.pos_iv_last && !i_stat.last;
                n_state = i_stat.pos_cipher ? S_SRD : S_FIN;
            end
            S_FILL: begin
                o_cmd.op = OP_FILL;
                if (i_stat.n_last) begin
                    n_state = S_KRD;
                end
            end
            S_KRD: begin
                o_cmd.op    = OP_RD_N;
                o_cmd.sched = 1'b1;
                n_state     = S_KJ;
            end
            S_KJ: begin
                o_cmd.op    = OP_RD_J;
                o_cmd.sched = 1'b1;
                n_state     = S_KSW;
            end
            S_KSW: begin
                o_cmd.op    = OP_SWAP;
                o_cmd.sched = 1'b1;
                n_state     = i_stat.n_last ? S_IDLE : S_KRD;
            end
            S_SRD: begin
                o_cmd.op = OP_RD_N;
                n_state  = S_SJ;
            end
            S_SJ: begin
                o_cmd.op = OP_RD_J;
                n_state  = S_SSW;
            end
            S_SSW: begin
                o_cmd.op = OP_SWAP;
                n_state  = S_STR;
            end
            S_STR: begin
                o_cmd.op = OP_RD_T;
                n_state  = S_SCAP;
            end
            S_SCAP: begin
                o_cmd.op = OP_CAP;
                n_state  = S_FIN;
            end
            S_FIN: begin
                // hold until the output register has room for a result
                if (i_stat.out_free || !i_stat.has_res) begin
                    o_cmd.op = OP_FIN;
                    n_sched  = 1'b0;
                    n_state  = r_sched ? S_FILL : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sched <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sched <= n_sched;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

>>> hdl/wfd_checker.sv
// ----------------------------------------------------------------------------
// wfd_checker
// Port-level checks on the decryptor's result words.
// ----------------------------------------------------------------------------
module wfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_plain_byte,
    input logic        o_plain_valid,
    input logic        o_frame_done,
    input logic [1:0]  o_frame_status
);
    import wfd_pkg::*;

    // A result word carries payload or ends a frame
    a_res_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_plain_valid || o_frame_done))
        else $error("empty result word");

    // Status is zero except on the frame's last result
    a_status_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_frame_done) |-> (o_frame_status == ST_OK))
        else $error("status without frame end");

    // No payload byte without its valid flag
    a_plain_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_plain_valid) |-> (o_plain_byte == 8'd0))
        else $error("plain byte without valid");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_plain_byte)
                                  && $stable(o_frame_status)))
        else $error("stalled result changed");

endmodule

bind wep_frame_decrypt_icv_check_top wfd_checker u_wfd_checker (.*);
